/* src/bpp_pkg.sv */
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared constants and types for the little-endian bit packer.
// ----------------------------------------------------------------------------
package bpp_pkg;

    localparam int MAX_SLOT_BITS = 64;
    localparam int BYTE_BITS     = 8;
    // offset (up to 63) plus slot (up to 64) fits in 16 bytes
    localparam int BUF_BITS      = 128;
    localparam int BUF_BYTES     = BUF_BITS / BYTE_BITS;
    localparam int CNT_BITS      = $clog2(BUF_BYTES + 1);

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_ELEMENT_WIDTH    = 2'd0,
        REG_SLOT_WIDTH       = 2'd1,
        REG_START_BIT_OFFSET = 2'd2
    } cfg_idx_t;

    // clamped configuration as seen by the pack stage
    typedef struct packed {
        logic [6:0] slot;
        logic [6:0] elem;
        logic [5:0] offset;
        logic       cfg_err;
    } pack_cfg_t;

    // one item's packed words handed to the output buffer
    typedef struct packed {
        logic                load;
        logic [BUF_BITS-1:0] data;
        logic [CNT_BITS-1:0] count;
        logic                last;
        logic                err;
    } buf_load_t;

endpackage

/* src/bpp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bpp_cfg_regs
// Configuration registers with clamping and validity check.
// ----------------------------------------------------------------------------
module bpp_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    output bpp_pkg::pack_cfg_t  cfg
);

    localparam logic [6:0] MAX_SLOT = 7'(bpp_pkg::MAX_SLOT_BITS);

    logic [6:0] elem_width_reg;
    logic [6:0] slot_width_reg;
    logic [5:0] start_offset_reg;
    logic [6:0] slot_clamped;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register file, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_width_reg   <= 7'd8;
            slot_width_reg   <= 7'd8;
            start_offset_reg <= 6'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bpp_pkg::cfg_idx_t'(cfg_index))
                bpp_pkg::REG_ELEMENT_WIDTH:    elem_width_reg   <= cfg_data;
                bpp_pkg::REG_SLOT_WIDTH:       slot_width_reg   <= cfg_data;
                bpp_pkg::REG_START_BIT_OFFSET: start_offset_reg <= cfg_data[5:0];
                default:                       ;
            endcase
        end
    end

    // clamp slot to 1..max and element width to 0..slot
    always_comb
    begin
        if (slot_width_reg == 7'd0)
            slot_clamped = 7'd1;
        else if (slot_width_reg > MAX_SLOT)
            slot_clamped = MAX_SLOT;
        else
            slot_clamped = slot_width_reg;
    end

    assign cfg.slot    = slot_clamped;
    assign cfg.elem    = (elem_width_reg > slot_clamped) ? slot_clamped : elem_width_reg;
    assign cfg.offset  = start_offset_reg;
    assign cfg.cfg_err = !((elem_width_reg != 7'd0) && (elem_width_reg <= slot_width_reg)
                           && (slot_width_reg <= MAX_SLOT));

endmodule

/* src/bpp_pack.sv */
// ----------------------------------------------------------------------------
// bpp_pack
// Input register and single-pass packing of one pattern into bytes.
// ----------------------------------------------------------------------------
module bpp_pack
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [63:0]         pattern,
    input  logic                last_item,
    input  bpp_pkg::pack_cfg_t  cfg,
    input  logic                buf_free,
    output bpp_pkg::buf_load_t  ld
);

    localparam int BB = bpp_pkg::BUF_BITS;

    logic                       in_full_reg;
    logic [63:0]                pat_reg;
    logic                       last_reg;
    logic [6:0]                 pend_bits_reg;
    logic [6:0]                 pend_bits_next;
    logic [2:0]                 pend_cnt_reg;
    logic [2:0]                 pend_cnt_next;
    logic                       at_start_reg;
    logic                       at_start_next;

    logic                       accept;
    logic                       xfer;
    logic [63:0]                mask;
    logic [63:0]                masked;
    logic                       too_wide;
    logic [5:0]                 sh;
    logic [BB-1:0]              stream;
    logic [6:0]                 total;
    logic [3:0]                 nfull;
    logic [2:0]                 rem;

    // input word register
    assign in_stall = in_full_reg && !buf_free;
    assign accept   = in_valid && !in_stall;
    assign xfer     = in_full_reg && buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (accept)
            in_full_reg <= 1'b1;
        else if (xfer)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pat_reg  <= pattern;
            last_reg <= last_item;
        end
    end

    // mask the pattern to the element width
    assign mask     = (cfg.elem >= 7'd64) ? '1 : ((64'd1 << cfg.elem[5:0]) - 64'd1);
    assign masked   = pat_reg & mask;
    assign too_wide = |(pat_reg & ~mask);

    // place the slot behind the pending bits or the start offset
    assign sh     = at_start_reg ? cfg.offset : {3'b000, pend_cnt_reg};
    assign stream = ({{(BB-64){1'b0}}, masked} << sh) | {{(BB-7){1'b0}}, pend_bits_reg};
    assign total  = 7'(sh) + cfg.slot;
    assign nfull  = total[6:3];
    assign rem    = total[2:0];

    // next partial byte state
    always_comb
    begin
        if (last_reg)
        begin
            pend_bits_next = 7'd0;
            pend_cnt_next  = 3'd0;
            at_start_next  = 1'b1;
        end
        else
        begin
            pend_bits_next = stream[{nfull, 3'b000} +: 7];
            pend_cnt_next  = rem;
            at_start_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= 7'd0;
            pend_cnt_reg  <= 3'd0;
            at_start_reg  <= 1'b1;
        end
        else if (xfer)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            at_start_reg  <= at_start_next;
        end
    end

    // hand the packed words to the output buffer
    assign ld.load  = xfer;
    assign ld.data  = stream;
    assign ld.count = (last_reg && (rem != 3'd0))
                      ? (bpp_pkg::CNT_BITS)'(nfull) + 1'b1
                      : (bpp_pkg::CNT_BITS)'(nfull);
    assign ld.last  = last_reg;
    assign ld.err   = cfg.cfg_err | too_wide;

    // a fresh stream never carries partial bits
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        at_start_reg |-> (pend_cnt_reg == 3'd0 && pend_bits_reg == 7'd0))
        else $error("partial bits held at stream start");

    // a last word reopens the stream
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && last_reg) |=> at_start_reg)
        else $error("stream not restarted after last word");

    // partial bits above the count stay zero
    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_bits_reg >> pend_cnt_reg) == 7'd0))
        else $error("stray bits in partial byte");

endmodule

/* src/bpp_out_buf.sv */
// ----------------------------------------------------------------------------
// bpp_out_buf
// Result register holding one item's bytes, shifted out one word a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module bpp_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  bpp_pkg::buf_load_t  ld,
    output logic                buf_free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          byte_value,
    output logic                last_byte,
    output logic                error
);

    localparam int CW = bpp_pkg::CNT_BITS;

    logic [bpp_pkg::BUF_BITS-1:0] data_reg;
    logic [CW-1:0]                count_reg;
    logic                         last_reg;
    logic                         err_reg;
    logic                         pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    // free when empty or when the final word leaves this cycle
    assign buf_free  = (count_reg == '0) || ((count_reg == CW'(1)) && pop);

    // word count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ld.load)
            count_reg <= ld.count;
        else if (pop)
            count_reg <= count_reg - CW'(1);
    end

    // byte shifter and item flags
    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            data_reg <= ld.data;
            last_reg <= ld.last;
            err_reg  <= ld.err;
        end
        else if (pop)
        begin
            data_reg <= data_reg >> bpp_pkg::BYTE_BITS;
        end
    end

    assign byte_value = data_reg[7:0];
    assign last_byte  = last_reg && (count_reg == CW'(1));
    assign error      = err_reg;

    // a taken word with no reload drops the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !ld.load) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("word count out of step");

    // a load only lands on a free buffer
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ld.load |-> buf_free)
        else $error("load over undelivered words");

endmodule

/* src/bit_pattern_packer.sv */
// ----------------------------------------------------------------------------
// bit_pattern_packer
// Packs element patterns LSB first into a byte stream with slot padding,
// start offset, flush on the last item and error flagging.
// ----------------------------------------------------------------------------
// Flow: an accepted word waits in the input register, is packed combinationally
//   and is loaded into the result register once that is free; its bytes are
//   then offered one a cycle while out_stall is low. The input register takes
//   one item a cycle while the result register is free; an item makes up to 9
//   bytes mid-stream, 16 on a stream's first item.
// Reset: asynchronous rst_n clears the buffers and partial byte, opens a new
//   stream, and loads element_width 8, slot_width 8, start_bit_offset 0.
module bit_pattern_packer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] pattern,
    input  logic        last_item,
    // output words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_value,
    output logic        last_byte,
    output logic        error
);

    bpp_pkg::pack_cfg_t cfg;
    bpp_pkg::buf_load_t ld;
    logic               buf_free;

    // configuration registers
    bpp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register and packing
    bpp_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pattern   (pattern),
        .last_item (last_item),
        .cfg       (cfg),
        .buf_free  (buf_free),
        .ld        (ld)
    );

    // result register and byte output
    bpp_out_buf u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld         (ld),
        .buf_free   (buf_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .error      (error)
    );

endmodule

/* dv/tb_bit_pattern_packer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bit_pattern_packer
// Self-checking bench for the little-endian bit packer: a directed table of
// corner words, then random streams under a range of register settings, with
// random gaps on both handshakes and one long hold on the byte side. Every
// accepted byte is compared with its typed table byte or a shadow packer.
// ----------------------------------------------------------------------------
module tb_bit_pattern_packer;

    localparam int          RAND_WORDS   = 90;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          LONG_HOLD    = 300;
    localparam int          MAX_SHOWN    = 10;
    localparam logic [1:0]  IDX_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       err;
    } out_byte_t;

    // one row of the directed table: a register set-up or a word
    typedef struct {
        logic        is_cfg;
        logic [6:0]  ew;
        logic [6:0]  sw;
        logic [5:0]  off;
        logic [63:0] pat;
        logic        lst;
        logic        typed;
        out_byte_t   fixed;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] pattern;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        error;

    // shadow packer state and registers
    logic [6:0]  sh_elem;
    logic [6:0]  sh_slot;
    logic [5:0]  sh_off;
    logic [7:0]  part_bits;
    int          part_cnt;
    logic        stream_fresh;

    out_byte_t   pred_bytes[$];
    out_byte_t   exp_bytes[$];
    step_t       steps[$];

    int          mismatches = 0;
    int          bytes_seen = 0;
    int          hold_reqs  = 0;
    int          hold_served = 0;
    logic        calm_tx = 1'b0;
    logic        calm_rx = 1'b0;

    bit_pattern_packer i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pattern    (pattern),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .error      (error)
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_SHOWN)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // one bit into the partial byte, emitting it when full
    function automatic void shift_bit(input logic b, input logic flag);
        part_bits[part_cnt] = b;
        part_cnt++;
        if (part_cnt == bpp_pkg::BYTE_BITS)
        begin
            pred_bytes.push_back('{part_bits, 1'b0, flag});
            part_bits = '0;
            part_cnt  = 0;
        end
    endfunction

    // bytes caused by one word under the current registers
    function automatic void pack_item(input logic [63:0] pat, input logic lst);
        int        slot;
        int        elem;
        int        i;
        int        n;
        logic      ok;
        logic      flag;
        out_byte_t ob;
        slot = sh_slot;
        elem = sh_elem;
        ok   = (sh_elem >= 1) && (sh_elem <= sh_slot)
               && (sh_slot <= bpp_pkg::MAX_SLOT_BITS);
        if (slot < 1)
            slot = 1;
        if (slot > bpp_pkg::MAX_SLOT_BITS)
            slot = bpp_pkg::MAX_SLOT_BITS;
        if (elem > slot)
            elem = slot;
        flag = !ok;
        if (elem < 64 && (pat >> elem) != 64'd0)
            flag = 1'b1;
        pred_bytes.delete();
        // leading zero bits open a stream
        if (stream_fresh)
        begin
            for (i = 0; i < sh_off; i++)
                shift_bit(1'b0, flag);
            stream_fresh = 1'b0;
        end
        for (i = 0; i < slot; i++)
            shift_bit((i < elem) ? pat[i] : 1'b0, flag);
        // flush and mark the final byte
        if (lst)
        begin
            if (part_cnt > 0)
            begin
                pred_bytes.push_back('{part_bits, 1'b0, flag});
                part_bits = '0;
                part_cnt  = 0;
            end
            n = pred_bytes.size();
            if (n > 0)
            begin
                ob = pred_bytes[n-1];
                ob.last = 1'b1;
                pred_bytes[n-1] = ob;
            end
            stream_fresh = 1'b1;
        end
    endfunction

    function automatic void add_cfg(input logic [6:0] ew, input logic [6:0] sw,
                                    input logic [5:0] off);
        step_t s;
        s = '{1'b1, ew, sw, off, 64'd0, 1'b0, 1'b0, '0};
        steps.push_back(s);
    endfunction

    function automatic void add_word(input logic [63:0] pat, input logic lst,
                                     input logic typed, input logic [7:0] v,
                                     input logic l, input logic e);
        step_t s;
        s = '{1'b0, 7'd0, 7'd0, 6'd0, pat, lst, typed, '{v, l, e}};
        steps.push_back(s);
    endfunction

    // all writes back to back, valid held high throughout
    task automatic load_config(input logic [6:0] ew, input logic [6:0] sw,
                               input logic [5:0] off);
        int k;
        cfg_valid <= 1'b1;
        for (k = 0; k < 4; k++)
        begin
            case (k)
                0:
                begin
                    cfg_index <= IDX_UNMAPPED;
                    cfg_data  <= 7'($urandom_range(0, 127));
                end
                1:
                begin
                    cfg_index <= bpp_pkg::REG_ELEMENT_WIDTH;
                    cfg_data  <= ew;
                end
                2:
                begin
                    cfg_index <= bpp_pkg::REG_SLOT_WIDTH;
                    cfg_data  <= sw;
                end
                default:
                begin
                    cfg_index <= bpp_pkg::REG_START_BIT_OFFSET;
                    cfg_data  <= {1'($urandom_range(0, 1)), off};
                end
            endcase
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        sh_elem = ew;
        sh_slot = sw;
        sh_off  = off;
    endtask

    task automatic wait_idle();
        while (exp_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one word, hold it until taken, then record its bytes
    task automatic send_word(input logic [63:0] pat, input logic lst,
                             input logic typed, input out_byte_t fixed);
        int gap;
        gap = (calm_tx || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pattern   <= pat;
        last_item <= lst;
        do @(posedge clk); while (in_stall);
        pack_item(pat, lst);
        if (typed)
            exp_bytes.push_back(fixed);
        else
            foreach (pred_bytes[k])
                exp_bytes.push_back(pred_bytes[k]);
    endtask

    // byte side back-pressure
    initial
    begin : rx_side
        int run;
        run = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                run = LONG_HOLD;
            end
            else if (run == 0 && !calm_rx && $urandom_range(0, 99) < 25)
                run = gap_len();
            if (run > 0)
            begin
                out_stall <= 1'b1;
                run--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // byte checker
    always @(posedge clk)
    begin : byte_check
        out_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_bytes.size() == 0)
                flag_mismatch($sformatf("unexpected byte %02h last %0b err %0b",
                                        byte_value, last_byte, error));
            else
            begin
                want = exp_bytes.pop_front();
                if (want.value !== byte_value || want.last !== last_byte ||
                    want.err !== error)
                    flag_mismatch($sformatf(
                        "byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                        bytes_seen, want.value, want.last, want.err,
                        byte_value, last_byte, error));
            end
            bytes_seen++;
        end
    end

    // stimulus
    initial
    begin : tx_side
        int          phase;
        int          rand_words;
        int          n;
        int          s;
        int          e;
        int          sel;
        logic [6:0]  ew;
        logic [6:0]  sw;
        logic [5:0]  off;
        logic [63:0] full;
        logic [63:0] mask;
        logic        pressure;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bpp_pkg::REG_ELEMENT_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pattern   = '0;
        last_item = 1'b0;

        sh_elem      = 7'd8;
        sh_slot      = 7'd8;
        sh_off       = 6'd0;
        part_bits    = '0;
        part_cnt     = 0;
        stream_fresh = 1'b1;

        // directed table, reset settings first
        add_word(64'hA5, 1'b1, 1'b1, 8'hA5, 1'b1, 1'b0);
        add_word(64'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0);
        add_word(64'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0);
        add_word(64'h100, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
        add_word({64{1'b1}}, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1);
        // widest element and slot
        add_cfg(7'd64, 7'd64, 6'd0);
        add_word({64{1'b1}}, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        add_word(64'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_word(64'h8000_0000_0000_0001, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // one-bit slots, words that make no byte, too wide on the last
        add_cfg(7'd1, 7'd1, 6'd0);
        add_word(64'd1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_word(64'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_word(64'd1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_word(64'd2, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // padded slot behind the largest offset
        add_cfg(7'd5, 7'd13, 6'd63);
        add_word(64'h1F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_word(64'h1F, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // largest offset plus widest slot gives the most bytes
        add_cfg(7'd64, 7'd64, 6'd63);
        add_word({64{1'b1}}, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // zero element width
        add_cfg(7'd0, 7'd8, 6'd0);
        add_word(64'd0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
        // element wider than slot
        add_cfg(7'd9, 7'd8, 6'd0);
        add_word(64'h1FF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // slot beyond the maximum
        add_cfg(7'd64, 7'd127, 6'd0);
        add_word(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // zero slot clamps to one bit
        add_cfg(7'd0, 7'd0, 6'd0);
        add_word(64'd1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
        add_cfg(7'd127, 7'd127, 6'd5);
        add_word(64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table
        foreach (steps[k])
        begin
            if (steps[k].is_cfg)
            begin
                in_valid <= 1'b0;
                wait_idle();
                load_config(steps[k].ew, steps[k].sw, steps[k].off);
            end
            else
                send_word(steps[k].pat, steps[k].lst, steps[k].typed, steps[k].fixed);
        end

        // random streams, one register setting per phase
        phase      = 0;
        rand_words = 0;
        while (rand_words < RAND_WORDS)
        begin
            in_valid <= 1'b0;
            wait_idle();
            pressure = (phase == 3);
            sel = $urandom_range(0, 99);
            if (pressure)
            begin
                ew  = 7'd64;
                sw  = 7'd64;
                off = 6'd0;
            end
            else if (sel < 60)
            begin
                sw  = 7'($urandom_range(1, 64));
                ew  = 7'($urandom_range(1, sw));
                off = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
            end
            else if (sel < 80)
            begin
                sw  = $urandom_range(0, 1) ? 7'd64 : 7'd1;
                ew  = $urandom_range(0, 1) ? sw : 7'd1;
                off = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            end
            else
            begin
                ew  = 7'($urandom_range(0, 127));
                sw  = 7'($urandom_range(0, 127));
                off = 6'($urandom_range(0, 63));
            end
            load_config(ew, sw, off);

            calm_tx = pressure || ($urandom_range(0, 3) == 0);
            calm_rx = ($urandom_range(0, 3) == 0);
            if (pressure)
                hold_reqs <= hold_reqs + 1;

            // effective element width for well-formed patterns
            s = sw;
            if (s < 1)
                s = 1;
            if (s > bpp_pkg::MAX_SLOT_BITS)
                s = bpp_pkg::MAX_SLOT_BITS;
            e = (ew > s) ? s : ew;
            mask = (e >= 64) ? {64{1'b1}} : ((64'd1 << e) - 64'd1);

            n = pressure ? 24 : $urandom_range(4, 14);
            repeat (n)
            begin
                full = {$urandom, $urandom};
                if ($urandom_range(0, 9) != 0)
                    full = full & mask;
                send_word(full, $urandom_range(0, 3) == 0, 1'b0, '0);
                rand_words++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
